// ===== hw/rtl/pixel_chunk_framer_counted_assert.svh =====
// ---------------------------------------------------------------------------
// Pixel chunk framer assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PIXEL_CHUNK_FRAMER_COUNTED_ASSERT_SVH
`define PIXEL_CHUNK_FRAMER_COUNTED_ASSERT_SVH

// Same-cycle implication.
`define PCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pcf_pkg.sv =====
// ---------------------------------------------------------------------------
// Pixel chunk framer package
// Shared widths, record codes and sequencer state type.
// ---------------------------------------------------------------------------
package pcf_pkg;

  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 5 * BYTE_W;
  localparam int OUT_D_W = PIX_W + 2 * BYTE_W;

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_PIX = 1'b1;

  localparam logic [BYTE_W-1:0] NO_DELAY = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HDR  = 3'b010,
    S_PIX  = 3'b100
  } seq_state_t;

endpackage

// ===== hw/rtl/pcf_ram.sv =====
// ---------------------------------------------------------------------------
// Chunk buffer RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module pcf_ram #(
  parameter int DEPTH  = 63,
  parameter int ADDR_W = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [pcf_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [pcf_pkg::PIX_W-1:0] rd_data
);
  import pcf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/pixel_chunk_framer_counted.sv =====
// A closing pixel or empty-frame item enters S_HDR; its header loads once the output is free.
// Pixel records follow one per cycle from the registered RAM read, absent back-pressure.
// A buffered pixel leaves the input ready for the next one; a closing one holds it off while the
// header and then its n pixels go out, by n replay reads through the single RAM read port.
// Reset (rst_n low, synchronous): buffer empty, next header is first of frame, delay 0.
// The RAM contents are not cleared.
// ---------------------------------------------------------------------------
// Pixel chunk framer
// Buffers pixels of a frame and emits chunks of a header plus pixel records.
// ---------------------------------------------------------------------------
`include "pixel_chunk_framer_counted_assert.svh"

module pixel_chunk_framer_counted #(
  parameter int MAX_CHUNK_PIXELS = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // cfg
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pcf_pkg::BYTE_W-1:0]  cfg_data,    // frame_delay
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pcf_pkg::PIX_W-1:0]   in_tdata,    // pos_x, pos_y, red, green, blue
  input  logic                        in_tlast,    // last_pixel
  input  logic                        in_tuser,    // empty_frame
  // output stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pcf_pkg::OUT_D_W-1:0] out_tdata,   // delay_value, pixel_count, out_x,
                                                   // out_y, out_red, out_green, out_blue
  output logic                        out_tlast,   // run_end
  output logic [1:0]                  out_tuser    // record_kind, frame_end
);
  import pcf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHUNK_PIXELS + 1);
  localparam int ADDR_W = (MAX_CHUNK_PIXELS > 1) ? $clog2(MAX_CHUNK_PIXELS) : 1;

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              first_r, first_nxt;
  logic [BYTE_W-1:0] delay_r;
  logic [BYTE_W-1:0] hdr_dly_r;
  logic [CNT_W-1:0]  hdr_cnt_r;
  logic              hdr_last_r;
  logic              hdr_empty_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_vld_r;

  logic               out_valid_r;
  logic [OUT_D_W-1:0] out_data_r;
  logic               out_kind_r;
  logic               out_fend_r;
  logic               out_rend_r;

  logic              in_fire, close, out_free, hdr_load, pix_load, pix_final;
  logic              rd_en, wr_en;
  logic [CNT_W-1:0]  cnt_inc, idx_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cnt_inc   = count_r + 1'b1;
  assign close     = !in_tuser && ((cnt_inc == CNT_W'(MAX_CHUNK_PIXELS)) || in_tlast);

  assign out_free  = !out_valid_r || out_tready;
  assign hdr_load  = (state_r == S_HDR) && out_free;
  assign pix_load  = (state_r == S_PIX) && rd_vld_r && out_free;
  assign idx_inc   = idx_r + 1'b1;
  assign pix_final = (idx_inc == hdr_cnt_r);

  assign wr_en   = in_fire && !in_tuser;
  assign rd_en   = (hdr_load && !hdr_empty_r) || (pix_load && !pix_final);
  assign rd_addr = hdr_load ? '0 : idx_inc[ADDR_W-1:0];

  pcf_ram #(
    .DEPTH  (MAX_CHUNK_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    first_nxt = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            count_nxt = '0;
            first_nxt = 1'b1;
            state_nxt = S_HDR;
          end else if (close) begin
            count_nxt = '0;
            first_nxt = in_tlast;
            state_nxt = S_HDR;
          end else begin
            count_nxt = cnt_inc;
          end
        end
      end
      S_HDR: begin
        if (hdr_load) begin
          state_nxt = hdr_empty_r ? S_IDLE : S_PIX;
        end
      end
      S_PIX: begin
        if (pix_load && pix_final) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      first_r     <= 1'b1;
      delay_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
      if (cfg_valid && cfg_ready) begin
        delay_r <= cfg_data;
      end
      if (rd_en) begin
        rd_vld_r <= 1'b1;
      end else if (pix_load) begin
        rd_vld_r <= 1'b0;
      end
      if (hdr_load || pix_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_empty_r <= in_tuser;
      hdr_last_r  <= in_tlast;
      hdr_cnt_r   <= in_tuser ? '0 : cnt_inc;
      hdr_dly_r   <= (in_tuser || first_r) ? delay_r : NO_DELAY;
    end
    if (hdr_load) begin
      idx_r <= '0;
    end else if (pix_load) begin
      idx_r <= idx_inc;
    end
    if (hdr_load) begin
      out_data_r <= {{PIX_W{1'b0}}, BYTE_W'(hdr_cnt_r), hdr_dly_r};
      out_kind_r <= KIND_HDR;
      out_rend_r <= hdr_empty_r;
      out_fend_r <= hdr_empty_r;
    end else if (pix_load) begin
      out_data_r <= {rd_data, {(2 * BYTE_W){1'b0}}};
      out_kind_r <= KIND_PIX;
      out_rend_r <= pix_final;
      out_fend_r <= pix_final && hdr_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_rend_r;
  assign out_tuser  = {out_fend_r, out_kind_r};

  `PCF_ASSERT_NOW(a_count_bound, 1'b1, count_r < CNT_W'(MAX_CHUNK_PIXELS), "count overflow")
  `PCF_ASSERT_NOW(a_rd_only_replay, rd_vld_r, state_r == S_PIX, "read data outside replay")
  `PCF_ASSERT_NOW(a_idx_bound, state_r == S_PIX, idx_r < hdr_cnt_r, "replay index past chunk")
  `PCF_ASSERT_NEXT(a_final_to_idle, pix_load && pix_final, state_r == S_IDLE, "replay overrun")
  `PCF_ASSERT_NEXT(a_close_to_hdr, in_fire && (in_tuser || close), state_r == S_HDR,
                   "closing transaction without header")

endmodule

// ===== bench/pixel_chunk_framer_counted_tb.sv =====
// ---------------------------------------------------------------------------
// Pixel chunk framer testbench
// Streams pixel frames into the framer and checks every header and pixel
// record it sends back. Frames range from single pixels to two full
// chunks plus one, with empty and aborted frames mixed in and the delay register
// stepped through its extremes. Both stream sides idle at random, and the
// output side is held off long enough at one point to back up the input.
// ---------------------------------------------------------------------------
module pixel_chunk_framer_counted_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  localparam int CHUNK_CAP = 63;
  localparam int PRINT_CAP = 40;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic       kind;
    logic [7:0] delay;
    logic [7:0] count;
    pixel_t     pix;
    logic       run_end;
    logic       frame_end;
  } record_t;

  class chunk_framing;
    logic [7:0] frame_delay;
    bit         first_chunk;
    pixel_t     open_chunk[$];
    record_t    expected_records[$];
    int         mismatches;
    int         checked;
    int         items;
    int         chunks;
    int         empties;

    function new();
      frame_delay = 8'h00;
      first_chunk = 1'b1;
    endfunction

    function void set_delay(logic [7:0] v);
      frame_delay = v;
    endfunction

    function void push_record(logic kind, logic [7:0] dly, logic [7:0] cnt, pixel_t p,
                              logic rend, logic fend);
      record_t r;
      r.kind      = kind;
      r.delay     = dly;
      r.count     = cnt;
      r.pix       = p;
      r.run_end   = rend;
      r.frame_end = fend;
      expected_records.push_back(r);
    endfunction

    // One accepted input transaction; queues the records it releases.
    function void accept_item(pixel_t p, bit last, bit empty);
      pixel_t blank;
      int     n;
      blank = '{default: '0};
      items++;
      if (empty) begin
        open_chunk.delete();
        first_chunk = 1'b1;
        empties++;
        push_record(KIND_HDR, frame_delay, 8'd0, blank, 1'b1, 1'b1);
        return;
      end
      open_chunk.push_back(p);
      if (open_chunk.size() < CHUNK_CAP && !last) return;
      n = open_chunk.size();
      chunks++;
      push_record(KIND_HDR, first_chunk ? frame_delay : NO_DELAY, n[7:0], blank,
                  1'b0, 1'b0);
      foreach (open_chunk[i])
        push_record(KIND_PIX, 8'd0, 8'd0, open_chunk[i], i == n - 1, (i == n - 1) && last);
      open_chunk.delete();
      first_chunk = last;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_record(record_t got);
      record_t want;
      checked++;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: unexpected record, expected none, actual kind %0d count %0h",
                   $time, got.kind, got.count);
        return;
      end
      want = expected_records.pop_front();
      compare_field("record_kind", 8'(want.kind), 8'(got.kind));
      compare_field("delay_value", want.delay, got.delay);
      compare_field("pixel_count", want.count, got.count);
      compare_field("out_x", want.pix.x, got.pix.x);
      compare_field("out_y", want.pix.y, got.pix.y);
      compare_field("out_red", want.pix.red, got.pix.red);
      compare_field("out_green", want.pix.green, got.pix.green);
      compare_field("out_blue", want.pix.blue, got.pix.blue);
      compare_field("run_end", 8'(want.run_end), 8'(got.run_end));
      compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata;   // pos_x, pos_y, red, green, blue
  logic                 in_tlast;   // last_pixel
  logic                 in_tuser;   // empty_frame
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_D_W-1:0]   out_tdata;  // delay_value, pixel_count, out_x, out_y,
                                    // out_red, out_green, out_blue
  logic                 out_tlast;  // run_end
  logic [1:0]           out_tuser;  // record_kind, frame_end

  chunk_framing framing = new();
  bit in_idle;
  bit out_idle;
  bit hold_req;

  pixel_chunk_framer_counted #(
    .MAX_CHUNK_PIXELS(CHUNK_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.x     = 8'($urandom);
    p.y     = 8'($urandom);
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    return p;
  endfunction

  task automatic send_item(input pixel_t p, input bit last, input bit empty);
    int gap;
    gap = pick_gap(in_idle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.blue, p.green, p.red, p.y, p.x};
    in_tlast  <= last;
    in_tuser  <= empty;
    do @(posedge clk); while (!in_tready);
    framing.accept_item(p, last, empty);
  endtask

  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_item(rand_pixel(), i == n - 1, 1'b0);
  endtask

  // Partial frame cut short by an empty-frame transaction.
  task automatic send_broken(input int n);
    for (int i = 0; i < n; i++) send_item(rand_pixel(), 1'b0, 1'b0);
    send_item(rand_pixel(), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (framing.expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    framing.set_delay(v);
  endtask

  initial begin : receiver
    int      stall;
    record_t got;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.delay     = out_tdata[7:0];
        got.count     = out_tdata[15:8];
        got.pix.x     = out_tdata[23:16];
        got.pix.y     = out_tdata[31:24];
        got.pix.red   = out_tdata[39:32];
        got.pix.green = out_tdata[47:40];
        got.pix.blue  = out_tdata[55:48];
        got.run_end   = out_tlast;
        got.kind      = out_tuser[0];
        got.frame_end = out_tuser[1];
        framing.check_record(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 400;
      end else if (stall == 0) begin
        stall = pick_gap(out_idle);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    pixel_t     p;
    logic [7:0] settings[5];
    int         phase_start;
    int         r;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    in_tuser  <= 1'b0;
    in_idle   = 1'b1;
    out_idle  = 1'b1;
    hold_req  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delay still at its reset value
    p = '{default: '0};
    send_item(p, 1'b1, 1'b0);
    write_delay(8'h5A);
    p = '{x: 8'hFF, y: 8'hFF, red: 8'hFF, green: 8'hFF, blue: 8'hFF};
    send_item(p, 1'b1, 1'b0);
    send_item(rand_pixel(), 1'b0, 1'b1);
    send_item(p, 1'b1, 1'b1);
    p = '{x: 8'hAA, y: 8'h55, red: 8'hAA, green: 8'h55, blue: 8'hAA};
    send_item(p, 1'b0, 1'b0);
    p = '{x: 8'h55, y: 8'hAA, red: 8'h55, green: 8'hAA, blue: 8'h55};
    send_item(p, 1'b0, 1'b0);
    send_item(rand_pixel(), 1'b1, 1'b0);
    // pixels dropped by an empty frame, then a fresh frame
    send_item(rand_pixel(), 1'b0, 1'b0);
    send_item(rand_pixel(), 1'b0, 1'b0);
    send_item(rand_pixel(), 1'b0, 1'b1);
    send_item(rand_pixel(), 1'b1, 1'b0);
    send_frame(4);

    settings = '{8'hFF, 8'($urandom_range(2, 254)), 8'h00, 8'h01, 8'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      write_delay(settings[ph]);
      in_idle     = (ph != 1);
      out_idle    = (ph != 1 && ph != 3);
      phase_start = framing.items;
      if (ph == 0) begin
        hold_req = 1'b1;
        send_frame(2 * CHUNK_CAP + 1);
      end
      if (ph == 2) send_frame(CHUNK_CAP);
      while (framing.items - phase_start < 30) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_frame($urandom_range(1, 8));
        else if (r < 65) send_item(rand_pixel(), 1'($urandom_range(0, 1)), 1'b1);
        else if (r < 78) send_broken($urandom_range(1, 12));
        else if (r < 90) send_frame($urandom_range(CHUNK_CAP - 3, CHUNK_CAP + 3));
        else if (r < 95) send_frame(CHUNK_CAP * $urandom_range(1, 2));
        else send_frame($urandom_range(9, 40));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d input transactions: %0d chunks, %0d empty frames, %0d records",
             framing.items, framing.chunks, framing.empties, framing.checked);
    $display("Delay register stepped through reset value, 0x5A and five more settings");
    if (framing.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
